### sv/pfd_pkg.sv
package pfd_pkg;

    localparam int SEEN_DEPTH_DEF = 64;
    localparam int VALUE_W        = 32;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // A lookup that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               hit;
    } pfd_query_t;

endpackage

### sv/parity_filter_distinct.sv
// A list element is taken into the launch register, walks the chain of seen cells one cell
// per cycle, has its hit flag registered on leaving the chain and then goes to the output
// register; an empty list marker goes straight to the output register. Both wait while the
// output is stalled, and a new item is accepted only once the previous result is registered.
// Reset: asynchronous, active low; the seen store is emptied and keep_odd returns to 0.
module parity_filter_distinct
    import pfd_pkg::*;
#(
    parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,       // keep_odd
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,    // [31:0] value
    input  logic               s_axis_tuser,    // [0] action
    input  logic               s_axis_tlast,    // is_last
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [VALUE_W-1:0] m_axis_tdata,    // [31:0] value_out
    output logic [2:0]         m_axis_tuser,    // [0] kept, [2:1] status
    output logic               m_axis_tlast     // end_of_list
);

    localparam int CNT_W = $clog2(SEEN_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t             state_reg,   state_next;
    pfd_query_t         launch_reg,  launch_next;
    logic [VALUE_W-1:0] value_reg,   value_next;
    logic               last_reg,    last_next;
    logic               action_reg,  action_next;
    logic               hit_reg,     hit_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic               keep_odd_reg, keep_odd_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_data_reg,  m_data_next;
    logic [2:0]         m_user_reg,  m_user_next;
    logic               m_last_reg,  m_last_next;

    pfd_query_t         chain [0:SEEN_DEPTH];
    logic               wr_en;
    logic               out_free;
    logic               pass;
    logic               kept;
    logic               has_room;
    status_t            status;

    assign chain[0] = launch_reg;

    for (genvar i = 0; i < SEEN_DEPTH; i++)
    begin : g_cell
        pfd_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .count     (count_reg),
            .wr_en     (wr_en),
            .wr_data   (value_reg),
            .query_in  (chain[i]),
            .query_out (chain[i+1])
        );
    end

    assign out_free = !m_valid_reg || m_axis_tready;
    assign pass     = (value_reg[0] == keep_odd_reg);
    assign kept     = pass && !hit_reg;
    assign has_room = (count_reg < CNT_W'(SEEN_DEPTH));
    assign status   = (kept && !has_room) ? ST_OVERFLOW : ST_OK;
    assign wr_en    = (state_reg == S_FINISH) && out_free && !action_reg && kept && has_room;

    always_comb
    begin
        state_next    = state_reg;
        launch_next   = launch_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        action_next   = action_reg;
        hit_next      = hit_reg;
        count_next    = count_reg;
        keep_odd_next = keep_odd_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;

        launch_next.valid = 1'b0;

        if (cfg_we)
        begin
            keep_odd_next = cfg_wdata;
        end

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    value_next  = s_axis_tdata;
                    last_next   = s_axis_tlast;
                    action_next = s_axis_tuser;
                    if (s_axis_tuser)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        launch_next.valid = 1'b1;
                        launch_next.value = s_axis_tdata;
                        launch_next.hit   = 1'b0;
                        state_next        = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (chain[SEEN_DEPTH].valid)
                begin
                    hit_next   = chain[SEEN_DEPTH].hit;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (action_reg)
                    begin
                        m_data_next = '0;
                        m_user_next = {ST_EMPTY, 1'b0};
                        m_last_next = 1'b1;
                        count_next  = '0;
                    end
                    else
                    begin
                        m_data_next = value_reg;
                        m_user_next = {status, kept};
                        m_last_next = last_reg;
                        if (last_reg)
                        begin
                            count_next = '0;
                        end
                        else if (wr_en)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launch_reg   <= '0;
            count_reg    <= '0;
            keep_odd_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            value_reg    <= '0;
            last_reg     <= 1'b0;
            action_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            m_data_reg   <= '0;
            m_user_reg   <= '0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launch_reg   <= launch_next;
            count_reg    <= count_next;
            keep_odd_reg <= keep_odd_next;
            m_valid_reg  <= m_valid_next;
            value_reg    <= value_next;
            last_reg     <= last_next;
            action_reg   <= action_next;
            hit_reg      <= hit_next;
            m_data_reg   <= m_data_next;
            m_user_reg   <= m_user_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SEEN_DEPTH))
        else $error("seen count exceeds store depth");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] == ST_EMPTY)) |-> (!m_axis_tuser[0] && m_axis_tlast))
        else $error("empty list result is kept or not marked last");

    a_overflow_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] == ST_OVERFLOW)) |-> m_axis_tuser[0])
        else $error("overflow status on a value that was not kept");

    a_chain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !chain[SEEN_DEPTH].valid)
        else $error("lookup still in the cell chain while accepting");
`endif

endmodule

### sv/pfd_cell.sv
module pfd_cell
    import pfd_pkg::*;
#(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   count,
    input  logic               wr_en,
    input  logic [VALUE_W-1:0] wr_data,
    input  pfd_query_t         query_in,
    output pfd_query_t         query_out
);

    logic [VALUE_W-1:0] stored_reg;
    pfd_query_t         query_reg;
    pfd_query_t         query_next;
    logic               active;

    // Only cells below the fill count hold a value of the current list.
    assign active = (CNT_W'(CELL_IDX) < count);

    always_comb
    begin
        query_next       = query_in;
        query_next.hit   = query_in.hit | (active && (stored_reg == query_in.value));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg <= '0;
        end
        else
        begin
            query_reg <= query_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (count == CNT_W'(CELL_IDX)))
        begin
            stored_reg <= wr_data;
        end
    end

    assign query_out = query_reg;

endmodule
